[hdl/ascii_setpoint_command_parser_assert.svh]
// Assertion macros for the setpoint command parser.
// Each macro expects clk and rst to be visible where it is used.
`ifndef ASCII_SETPOINT_COMMAND_PARSER_ASSERT_SVH
`define ASCII_SETPOINT_COMMAND_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ascp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and character constants for the setpoint command parser.
// No dependencies; used by the result channel interface, the top level and the testbench.
package ascp_pkg;

  localparam logic [7:0] CH_ZERO      = 8'd48;
  localparam logic [7:0] CH_NINE      = 8'd57;
  localparam logic [7:0] CH_MINUS     = 8'd45;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;

  localparam logic [7:0] CMD_RUN      = 8'd1;
  localparam logic [7:0] CMD_STOP     = 8'd2;
  localparam logic [7:0] CMD_SETPOINT = 8'd3;
  localparam logic [7:0] CMD_BAND     = 8'd4;

  localparam int unsigned CMD_LEN = 4;
  localparam logic [1:0]  LAST_CHAR_IDX = 2'(CMD_LEN - 1);

  typedef enum logic [1:0] {
    KIND_TX       = 2'd0,
    KIND_SETPOINT = 2'd1,
    KIND_BAND     = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         tx_byte;
    logic signed [15:0] value;
    logic               last;
  } result_t;

endpackage

[hdl/ascp_rx_if.sv]
`timescale 1ns / 1ps
// Request channel that carries one received serial byte.
// Depends on nothing outside itself.
interface ascp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[hdl/ascp_result_if.sv]
`timescale 1ns / 1ps
// Request channel that carries one parser result.
// Depends on ascp_pkg for the result kind type.
interface ascp_result_if import ascp_pkg::*;;
  logic               valid;
  logic               ready;
  kind_t              kind;
  logic [7:0]         tx_byte;
  logic signed [15:0] value;
  logic               last;

  modport source (output valid, output kind, output tx_byte, output value, output last,
                  input ready);
  modport sink   (input valid, input kind, input tx_byte, input value, input last,
                  output ready);
endinterface

[hdl/ascii_setpoint_command_parser.sv]
`timescale 1ns / 1ps
// Setpoint command parser: turns received serial bytes into echoes and stores.
// Depends on ascp_pkg, ascp_rx_if, ascp_result_if and the assertion macro header.
//
// Each received byte is registered, decoded combinationally and its one or two
// results are loaded into a two-entry result buffer that drives the output.
// A byte that causes one result can be taken every cycle while the result
// channel is ready; a byte that causes two results (a rejected byte, or a
// setpoint or band command completed while running) occupies the single
// result port for both, so the next byte is loaded only as its second is taken.
// Each byte passes through the stage register and then the result buffer
// before its first result is offered. Result kind 0 carries a byte to transmit,
// kind 1 a signed setpoint in tenths of a degree, kind 2 a band.
module ascii_setpoint_command_parser import ascp_pkg::*; (
  input logic          clk,
  input logic          rst,
  ascp_rx_if.sink      rx,
  ascp_result_if.source result
);

  logic       stage_valid;
  logic [7:0] stage_byte;

  logic [1:0] char_count;
  logic [7:0] held_chars [3];
  logic       running;

  result_t    slot0;
  result_t    slot1;
  logic       slot0_valid;
  logic       slot1_valid;

  logic       result_fire;
  logic       buf_free;
  logic       load;

  logic       char_ok;
  logic       cmd_done;
  logic [7:0] code;
  logic [7:0] d1;
  logic [7:0] d2;
  logic [7:0] d3;
  logic [11:0] low;
  logic [15:0] full;
  logic       neg;
  logic       running_next;
  result_t    r0;
  result_t    r1;
  logic       two_results;

  assign result_fire = slot0_valid && result.ready;
  assign buf_free    = !slot0_valid || (result_fire && !slot1_valid);
  assign load        = stage_valid && buf_free;
  assign rx.ready    = !stage_valid || load;

  assign result.valid   = slot0_valid;
  assign result.kind    = slot0.kind;
  assign result.tx_byte = slot0.tx_byte;
  assign result.value   = slot0.value;
  assign result.last    = slot0.last;

  always_comb begin
    char_ok  = (stage_byte inside {[CH_ZERO:CH_NINE]}) || (stage_byte == CH_MINUS);
    cmd_done = char_ok && (char_count == LAST_CHAR_IDX);
    code     = held_chars[0] - CH_ZERO;
    d1       = held_chars[1] - CH_ZERO;
    d2       = held_chars[2] - CH_ZERO;
    d3       = stage_byte - CH_ZERO;
    low      = 12'(d2) * 12'd10 + 12'(d3);
    full     = 16'(d1) * 16'd100 + 16'(low);
    neg      = (held_chars[1] == CH_MINUS);

    running_next = running;
    two_results  = 1'b0;
    r0 = '{kind: KIND_TX, tx_byte: stage_byte, value: '0, last: 1'b1};
    r1 = '{kind: KIND_TX, tx_byte: CH_BACKSPACE, value: '0, last: 1'b1};

    if (!char_ok) begin
      two_results = 1'b1;
      r0.last     = 1'b0;
    end else if (cmd_done) begin
      case (code)
        CMD_RUN: begin
          running_next = 1'b1;
        end
        CMD_STOP: begin
          running_next = 1'b0;
        end
        CMD_SETPOINT: begin
          if (running) begin
            two_results = 1'b1;
            r0.last     = 1'b0;
            r1.kind     = KIND_SETPOINT;
            r1.tx_byte  = '0;
            r1.value    = neg ? (16'd0 - 16'(low)) : full;
          end
        end
        CMD_BAND: begin
          if (running) begin
            two_results = 1'b1;
            r0.last     = 1'b0;
            r1.kind     = KIND_BAND;
            r1.tx_byte  = '0;
            r1.value    = {8'd0, neg ? low[7:0] : full[7:0]};
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      stage_valid <= 1'b1;
    end else if (load) begin
      stage_valid <= 1'b0;
    end
    if (rx.valid && rx.ready) begin
      stage_byte <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
      running    <= 1'b0;
    end else if (load && char_ok) begin
      char_count <= char_count + 2'd1;
      running    <= running_next;
    end
    if (load && char_ok && !cmd_done) begin
      held_chars[char_count] <= stage_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot0_valid <= 1'b0;
      slot1_valid <= 1'b0;
    end else if (load) begin
      slot0_valid <= 1'b1;
      slot1_valid <= two_results;
    end else if (result_fire) begin
      slot0_valid <= slot1_valid;
      slot1_valid <= 1'b0;
    end
    if (load) begin
      slot0 <= r0;
      slot1 <= r1;
    end else if (result_fire && slot1_valid) begin
      slot0 <= slot1;
    end
  end

`include "ascii_setpoint_command_parser_assert.svh"

  `ASCP_ASSERT_NOW(a_slot_order, slot1_valid, slot0_valid, "second result without first")
  `ASCP_ASSERT_NOW(a_pair_complete, slot0_valid && !slot0.last, slot1_valid,
                   "non-final result with nothing after it")
  `ASCP_ASSERT_NOW(a_second_is_last, slot1_valid, slot1.last, "second result not final")
  `ASCP_ASSERT_NEXT(a_count_wrap, load && cmd_done, char_count == 2'd0,
                    "character count did not wrap after a command")

endmodule

[tb/sv/ascii_setpoint_command_parser_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the setpoint command parser: directed commands,
// then random command streams under varying stalls on both channels.
// Depends on ascp_pkg, ascp_rx_if, ascp_result_if and the parser RTL.
module ascii_setpoint_command_parser_tb;
  import ascp_pkg::*;

  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 10;

  logic clk = 1'b0;
  logic rst;

  ascp_rx_if     rx_ch ();
  ascp_result_if res_ch ();

  ascii_setpoint_command_parser u_top (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .result (res_ch)
  );

  always #4 clk = ~clk;

  // Predicted parser state.
  logic [1:0] cmd_len = '0;
  logic [7:0] cmd_chars [3];
  logic       run_mode = 1'b0;

  result_t pending_results [$];

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int stalled_cycles = 0;
  int errors = 0;
  int n_sent = 0;
  int n_rejected = 0;
  int n_setpoints = 0;
  int n_bands = 0;

  function automatic bit is_command_char(input logic [7:0] b);
    return (b >= CH_ZERO && b <= CH_NINE) || b == CH_MINUS;
  endfunction

  function automatic void queue_result(input kind_t k, input logic [7:0] tx,
                                       input logic [15:0] v, input logic lst);
    result_t r;
    r.kind    = k;
    r.tx_byte = tx;
    r.value   = v;
    r.last    = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b);
    logic [7:0] code;
    logic [7:0] d1;
    logic [7:0] d2;
    logic [7:0] d3;
    int         lowv;
    int         fullv;
    logic       is_minus;
    if (!is_command_char(b)) begin
      queue_result(KIND_TX, b, 16'd0, 1'b0);
      queue_result(KIND_TX, CH_BACKSPACE, 16'd0, 1'b1);
      n_rejected++;
      return;
    end
    if (cmd_len != LAST_CHAR_IDX) begin
      cmd_chars[cmd_len] = b;
      cmd_len = cmd_len + 2'd1;
      queue_result(KIND_TX, b, 16'd0, 1'b1);
      return;
    end
    cmd_len = '0;
    code = cmd_chars[0] - CH_ZERO;
    d1 = cmd_chars[1] - CH_ZERO;
    d2 = cmd_chars[2] - CH_ZERO;
    d3 = b - CH_ZERO;
    lowv = int'(d2) * 10 + int'(d3);
    fullv = int'(d1) * 100 + lowv;
    is_minus = (cmd_chars[1] == CH_MINUS);
    if (code == CMD_RUN) begin
      run_mode = 1'b1;
    end else if (code == CMD_STOP) begin
      run_mode = 1'b0;
    end else if (code == CMD_SETPOINT && run_mode) begin
      queue_result(KIND_TX, b, 16'd0, 1'b0);
      queue_result(KIND_SETPOINT, 8'd0, is_minus ? 16'(-lowv) : 16'(fullv), 1'b1);
      n_setpoints++;
      return;
    end else if (code == CMD_BAND && run_mode) begin
      queue_result(KIND_TX, b, 16'd0, 1'b0);
      queue_result(KIND_BAND, 8'd0, {8'd0, 8'(is_minus ? lowv : fullv)}, 1'b1);
      n_bands++;
      return;
    end
    queue_result(KIND_TX, b, 16'd0, 1'b1);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    parse_rx_byte(b);
    n_sent++;
  endtask

  task automatic send_command(input logic [7:0] first, input string rest);
    send_byte(first);
    for (int i = 0; i < rest.len(); i++) send_byte(rest[i]);
  endtask

  task automatic wait_for_results();
    rx_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] random_rejected();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_command_char(b));
    return b;
  endfunction

  function automatic logic [7:0] random_cmd_char();
    if ($urandom_range(0, 99) < 15) return CH_MINUS;
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  task automatic send_with_noise(input logic [7:0] b);
    if ($urandom_range(0, 99) < 6) send_byte(random_rejected());
    send_byte(b);
  endtask

  task automatic send_random_command();
    logic [7:0] first;
    logic [7:0] d;
    int         pick;
    // A broken command left by noise is completed with random characters.
    while (cmd_len != 0) send_byte(random_cmd_char());
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat (4) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (pick < 22) begin
      first = CH_ZERO + CMD_RUN;
    end else if (pick < 30) begin
      first = CH_ZERO + CMD_STOP;
    end else if (pick < 60) begin
      first = CH_ZERO + CMD_SETPOINT;
    end else if (pick < 88) begin
      first = CH_ZERO + CMD_BAND;
    end else if (pick < 95) begin
      d = 8'($urandom_range(CMD_BAND, 9));
      if (d == CMD_BAND) d = 8'd0;
      first = CH_ZERO + d;
    end else begin
      first = CH_MINUS;
    end
    send_with_noise(first);
    repeat (3) send_with_noise(random_cmd_char());
  endtask

  task automatic test_rejects_inside_command();
    send_byte(CH_ZERO + CMD_RUN);
    send_byte(8'h00);
    send_byte(CH_ZERO);
    send_byte(8'hFF);
    send_byte(CH_ZERO);
    send_byte(CH_NINE + 8'd1);
    send_byte(CH_ZERO);
  endtask

  task automatic test_setpoint_and_band();
    send_command(CH_ZERO + CMD_SETPOINT, "--5");
    send_command(CH_ZERO + CMD_BAND, "999");
  endtask

  task automatic test_stopped_and_unknown();
    send_command(CH_ZERO + CMD_STOP, "000");
    send_command(CH_ZERO + CMD_SETPOINT, "123");
    send_command(CH_MINUS, "000");
  endtask

  task automatic test_random_stream(input int src_pct, input int snk_pct, input int count);
    int target;
    target = n_sent + count;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    while (n_sent < target) send_random_command();
  endtask

  task automatic test_output_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_request = 1'b1;
    repeat (12) send_random_command();
  endtask

  task automatic test_drain_pause();
    wait_for_results();
    repeat (8) send_random_command();
  endtask

  task automatic note_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      note_error($sformatf("unexpected result kind=%0d tx=%02h value=%0d last=%0d",
                           res_ch.kind, res_ch.tx_byte, res_ch.value, res_ch.last));
      return;
    end
    want = pending_results.pop_front();
    if (res_ch.kind !== want.kind || res_ch.tx_byte !== want.tx_byte ||
        res_ch.value !== want.value || res_ch.last !== want.last) begin
      note_error($sformatf({"expected kind=%0d tx=%02h value=%0d last=%0d, ",
                            "got kind=%0d tx=%02h value=%0d last=%0d"},
                           want.kind, want.tx_byte, want.value, want.last,
                           res_ch.kind, res_ch.tx_byte, res_ch.value, res_ch.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) check_result();
  end

  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding.", pending_results.size());
        $display("ascii_setpoint_command_parser_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = 8'd0;
    res_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_rejects_inside_command();
    test_setpoint_and_band();
    test_stopped_and_unknown();
    test_random_stream(33, 62, 330);
    test_random_stream(62, 33, 330);
    test_random_stream(0, 0, 330);
    test_output_backpressure();
    test_drain_pause();

    wait_for_results();
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes (%0d rejected); checked %0d setpoint and %0d band stores,",
             n_sent, n_rejected, n_setpoints, n_bands);
    $display("including a long output stall and a full drain pause.");
    if (errors == 0) begin
      $display("ascii_setpoint_command_parser_tb: done, clean");
    end else begin
      $display("%0d mismatches in total.", errors);
      $display("ascii_setpoint_command_parser_tb: done, errors");
    end
    $finish;
  end

endmodule
